// ===== rtl/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types, character codes and the hex digit lookup for the backslash
// escape decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bed_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  localparam int unsigned GROUP_MAX = 3;

  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_ESC  = 2'd1,
    PH_HEX1 = 2'd2,
    PH_HEX2 = 2'd3
  } phase_t;

  // bytes produced by one character, emitted from index 0 up
  typedef struct packed {
    logic [GROUP_MAX-1:0][7:0] data;
    logic [1:0]                count;
    logic                      last;   // applies to the final byte of the group
  } group_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bed_char_if.sv =====
// ----------------------------------------------------------------------------
// bed_char_if
// Character stream channel: valid/ready with one escaped character.
// ----------------------------------------------------------------------------
`default_nettype none

interface bed_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       final_char;

  modport source (output valid, ch, final_char, input ready);
  modport sink   (input valid, ch, final_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/bed_byte_if.sv =====
// ----------------------------------------------------------------------------
// bed_byte_if
// Decoded byte channel: valid/ready with one byte and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bed_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/bed_decode.sv =====
// ----------------------------------------------------------------------------
// bed_decode
// Escape decoding for one character: from the current phase and held digit,
// gives the group of output bytes and the next phase and held digit.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_decode
  import bed_pkg::*;
(
  input  phase_t     phase,
  input  logic [3:0] held,
  input  logic [7:0] ch,
  input  logic       final_char,
  output group_t     group,
  output phase_t     phase_next,
  output logic [3:0] held_next
);

  hex_t       hx;
  logic [7:0] mapped;

  assign hx = hex_decode(ch);

  always_comb begin
    case (ch)
      CH_ZERO: mapped = BYTE_NUL;
      CH_N:    mapped = BYTE_LF;
      CH_R:    mapped = BYTE_CR;
      CH_T:    mapped = BYTE_TAB;
      default: mapped = ch;
    endcase
  end

  always_comb begin
    group.data  = '0;
    group.count = 2'd0;
    group.last  = 1'b0;
    phase_next  = PH_TEXT;
    held_next   = held;
    unique case (phase)
      PH_TEXT: begin
        if (ch == CH_BACKSLASH && !final_char) begin
          phase_next = PH_ESC;
        end else begin
          group.data[0] = ch;
          group.count   = 2'd1;
          group.last    = final_char;
        end
      end
      PH_ESC: begin
        if (ch == CH_X && !final_char) begin
          phase_next = PH_HEX1;
        end else begin
          group.data[0] = mapped;
          group.count   = 2'd1;
          group.last    = final_char;
        end
      end
      PH_HEX1: begin
        if (final_char) begin
          group.data[0] = CH_X;
          group.data[1] = ch;
          group.count   = 2'd2;
          group.last    = 1'b1;
        end else if (hx.ok) begin
          held_next  = hx.value;
          phase_next = PH_HEX2;
        end else begin
          // failed parse: backslash, x, ch; a backslash ch opens an escape
          group.data[0] = CH_BACKSLASH;
          group.data[1] = CH_X;
          group.data[2] = ch;
          if (ch == CH_BACKSLASH) begin
            group.count = 2'd2;
            phase_next  = PH_ESC;
          end else begin
            group.count = 2'd3;
          end
        end
      end
      PH_HEX2: begin
        group.data[0] = hx.ok ? {held, hx.value} : {4'd0, held};
        group.count   = 2'd1;
        group.last    = final_char;
      end
      default: begin
        phase_next = PH_TEXT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bed_out_buf.sv =====
// ----------------------------------------------------------------------------
// bed_out_buf
// Result register: holds one group of decoded bytes, handed out one per
// cycle while ready. A new group loads when empty or as the last byte leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module bed_out_buf
  import bed_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  group_t        group,
  output logic          can_load,
  bed_byte_if.source    bytes
);

  logic [GROUP_MAX-1:0][7:0] data;
  logic [1:0]                remaining;
  logic [1:0]                pos;
  logic                      last;
  logic                      take;

  assign take     = bytes.valid && bytes.ready;
  assign can_load = (remaining == 2'd0) || (remaining == 2'd1 && bytes.ready);

  assign bytes.valid    = (remaining != 2'd0);
  assign bytes.out_byte = data[pos];
  assign bytes.out_last = last && (remaining == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
      pos       <= 2'd0;
    end else if (load) begin
      remaining <= group.count;
      pos       <= 2'd0;
    end else if (take) begin
      remaining <= remaining - 2'd1;
      pos       <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= group.data;
      last <= group.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/backslash_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Decodes C style backslash escapes in a character stream into bytes.
//
//   channel  role    payload
//   chars    sink    ch[7:0], final_char
//   bytes    source  out_byte[7:0], out_last
//
// One character enters per cycle into the input register; the decoder sits
// between it and the result register. A character yields zero to three bytes,
// which leave at one byte per cycle while ready, so the input takes one
// character a cycle unless a two or three byte group is still draining or
// bytes.ready is low. Reset returns to plain text with both registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module backslash_escape_decoder
  import bed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bed_char_if.sink   chars,
  bed_byte_if.source bytes
);

  logic       in_full;
  logic [7:0] in_ch;
  logic       in_fin;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] held;
  logic [3:0] held_next;

  group_t     group;
  logic       can_load;
  logic       load;

  assign load        = in_full && can_load;
  assign chars.ready = !in_full || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_ch  <= chars.ch;
      in_fin <= chars.final_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TEXT;
      held  <= 4'd0;
    end else if (load) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

  bed_decode u_decode (
    .phase      (phase),
    .held       (held),
    .ch         (in_ch),
    .final_char (in_fin),
    .group      (group),
    .phase_next (phase_next),
    .held_next  (held_next)
  );

  bed_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .group    (group),
    .can_load (can_load),
    .bytes    (bytes)
  );

endmodule

`default_nettype wire
